// ----- rtl/fcpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame cache package
// Shared types, codes and constants of the frame cache with priority eviction.
// ----------------------------------------------------------------------------
package fcpe_pkg;

  localparam int unsigned ClipW  = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned LimitW = 40;
  localparam int unsigned WinW   = 10;
  localparam int unsigned MargW  = 14;
  localparam int unsigned CfgIdxW = 2;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_EXACT  = 2'd1;
  localparam logic [1:0] REQ_NEAR   = 2'd2;
  localparam logic [1:0] REQ_INVAL  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_EVICT = 2'd0;
  localparam logic [1:0] KIND_HIT   = 2'd1;
  localparam logic [1:0] KIND_MISS  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BYTE_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXACT_WIN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAST_MARG  = 2'd2;

  localparam logic [LimitW-1:0] BYTE_LIMIT_RST = 40'd268435456;
  localparam logic [WinW-1:0]   EXACT_WIN_RST  = 10'd45;
  localparam logic [MargW-1:0]  PAST_MARG_RST  = 14'd150;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ClipW-1:0] clip_id;
    logic [TimeW-1:0] timestamp_ms;
    logic [SizeW-1:0] frame_bytes;
    logic [TagW-1:0]  frame_handle;
    logic [TimeW-1:0] max_distance_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]      result_kind;
    logic [TagW-1:0] out_handle;
    logic            last;
  } res_t;

  // datapath scan modes
  localparam logic [2:0] SCAN_OTHER = 3'd0; // first entry of another clip
  localparam logic [2:0] SCAN_PAST  = 3'd1; // first past entry of this clip
  localparam logic [2:0] SCAN_LATE  = 3'd2; // latest timestamp
  localparam logic [2:0] SCAN_EXACT = 3'd3;
  localparam logic [2:0] SCAN_NEAR  = 3'd4;
  localparam logic [2:0] SCAN_INVAL = 3'd5; // compaction pass

  // controller to datapath
  typedef struct packed {
    logic       load_req;   // capture request
    logic       scan_start; // clear scan registers, begin at entry 0
    logic       scan_step;  // examine one entry
    logic [2:0] mode;
    logic       remove;     // remove found entry (shift step)
    logic       shift_start;
    logic       append;
    logic       inval_fin;  // commit compaction count
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_evict;  // table non-empty and full, or new frame would exceed byte limit
    logic scan_end;    // scan index reached entry count
    logic found;
    logic inval_match; // current entry of invalidate scan matches
  } sts_t;

endpackage

// ----- rtl/fcpe_if.sv -----
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload per transfer between a source and a sink.
// ----------------------------------------------------------------------------
interface fcpe_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/fcpe_dp.sv -----
// ----------------------------------------------------------------------------
// Frame cache datapath
// Entry table, byte total, request register and one-entry-per-cycle scanner, paused while not stepped.
// ----------------------------------------------------------------------------
module fcpe_dp #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fcpe_pkg::cmd_t                 cmd,
  output fcpe_pkg::sts_t                 sts,
  input  fcpe_pkg::req_t                 req_in,
  input  logic                           cfg_we,
  input  logic [fcpe_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [fcpe_pkg::LimitW-1:0]    cfg_data,
  output logic [fcpe_pkg::TagW-1:0]      hit_tag,
  output logic [fcpe_pkg::TagW-1:0]      cur_tag
);
  import fcpe_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TotW = SizeW + CntW;
  localparam int unsigned CmpW = (TotW > LimitW) ? TotW + 1 : LimitW + 1;

  // configuration registers
  logic [LimitW-1:0] byte_limit;
  logic [WinW-1:0]   exact_win;
  logic [MargW-1:0]  past_marg;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit <= BYTE_LIMIT_RST;
      exact_win  <= EXACT_WIN_RST;
      past_marg  <= PAST_MARG_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BYTE_LIMIT: byte_limit <= cfg_data;
        CFG_EXACT_WIN:  exact_win  <= cfg_data[WinW-1:0];
        CFG_PAST_MARG:  past_marg  <= cfg_data[MargW-1:0];
        default: ;
      endcase
    end
  end

  // table (registers, each entry read at the scan or shift index)
  logic [ClipW-1:0] e_clip [TABLE_DEPTH];
  logic [TimeW-1:0] e_time [TABLE_DEPTH];
  logic [SizeW-1:0] e_size [TABLE_DEPTH];
  logic [TagW-1:0]  e_tag  [TABLE_DEPTH];
  logic [CntW-1:0]  count;
  logic [TotW-1:0]  total;
  req_t             rq;

  logic [CntW-1:0] si;      // scan / read index
  logic [CntW-1:0] wi;      // write index (shift / compaction)
  logic            found;
  logic [IdxW-1:0] best_i;
  logic [TimeW:0]  best_d;
  logic [TagW-1:0] best_tag;

  logic [IdxW-1:0]  ri;
  logic [ClipW-1:0] c_clip;
  logic [TimeW-1:0] c_time;
  logic [TimeW:0]   gap;
  logic             same_clip;
  logic             is_past;
  logic             hit;
  logic [IdxW-1:0]  wix;

  assign ri = si[IdxW-1:0];
  assign wix = wi[IdxW-1:0];
  assign c_clip = e_clip[ri];
  assign c_time = e_time[ri];
  assign cur_tag = e_tag[ri];
  assign same_clip = (c_clip == rq.clip_id);
  assign gap = (c_time > rq.timestamp_ms) ?
               {1'b0, c_time} - {1'b0, rq.timestamp_ms} :
               {1'b0, rq.timestamp_ms} - {1'b0, c_time};
  assign is_past = ({1'b0, c_time} + {{(TimeW+1-MargW){1'b0}}, past_marg}) <
                   {1'b0, rq.timestamp_ms};

  // match condition of the current entry for each scan mode
  always_comb begin
    case (cmd.mode)
      SCAN_OTHER: hit = !same_clip;
      SCAN_PAST:  hit = is_past;
      SCAN_LATE:  hit = !found || ({1'b0, c_time} > best_d);
      SCAN_EXACT: hit = same_clip && (gap < {{(TimeW+1-WinW){1'b0}}, exact_win});
      SCAN_NEAR:  hit = same_clip && (gap <= {1'b0, rq.max_distance_ms}) &&
                        (!found || gap < best_d);
      default:    hit = same_clip;
    endcase
  end

  logic [CmpW-1:0] sum;
  assign sum = CmpW'(total) + CmpW'(rq.frame_bytes);

  assign sts.need_evict = (count != '0) &&
                          ((count >= CntW'(TABLE_DEPTH)) || (sum > CmpW'(byte_limit)));
  assign sts.scan_end   = (si >= count);
  assign sts.found      = found;
  assign sts.inval_match = same_clip;
  assign hit_tag = best_tag;

  // scan and shift indexes, best-entry registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) rq <= req_in;
    if (cmd.scan_start) begin
      si <= '0;
      wi <= '0;
      found <= 1'b0;
      best_i <= '0;
      best_d <= '0;
      best_tag <= '0;
    end else if (cmd.shift_start) begin
      wi <= CntW'(best_i);
      si <= CntW'(best_i) + CntW'(1);
    end else if (cmd.remove) begin
      wi <= wi + CntW'(1);
      si <= si + CntW'(1);
    end else if (cmd.scan_step) begin
      si <= si + CntW'(1);
      if (cmd.mode == SCAN_INVAL) begin
        if (!same_clip) wi <= wi + CntW'(1);
      end else if (hit) begin
        found <= 1'b1;
        best_i <= ri;
        best_tag <= cur_tag;
        best_d <= (cmd.mode == SCAN_LATE) ? {1'b0, c_time} : gap;
      end
    end
  end

  // table writes: shift down, compaction, append
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else begin
      if (cmd.shift_start) begin
        total <= total - TotW'(e_size[best_i]);
        if (count == CntW'(1) || CntW'(best_i) + CntW'(1) >= count)
          count <= count - CntW'(1);
      end
      if (cmd.remove) begin
        e_clip[wix] <= c_clip;
        e_time[wix] <= c_time;
        e_size[wix] <= e_size[ri];
        e_tag[wix]  <= cur_tag;
        if (wi + CntW'(2) >= count) count <= count - CntW'(1);
      end
      if (cmd.scan_step && cmd.mode == SCAN_INVAL && !sts.scan_end) begin
        if (same_clip) begin
          total <= total - TotW'(e_size[ri]);
        end else begin
          e_clip[wix] <= c_clip;
          e_time[wix] <= c_time;
          e_size[wix] <= e_size[ri];
          e_tag[wix]  <= cur_tag;
        end
      end
      if (cmd.inval_fin) count <= wi;
      if (cmd.append) begin
        if (count < CntW'(TABLE_DEPTH)) begin
          e_clip[count[IdxW-1:0]] <= rq.clip_id;
          e_time[count[IdxW-1:0]] <= rq.timestamp_ms;
          e_size[count[IdxW-1:0]] <= rq.frame_bytes;
          e_tag[count[IdxW-1:0]]  <= rq.frame_handle;
          count <= count + CntW'(1);
          total <= total + TotW'(rq.frame_bytes);
        end
      end
    end
  end

endmodule

// ----- rtl/fcpe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Frame cache controller
// Sequences scans, eviction, shifting and result transfers per request.
// ----------------------------------------------------------------------------
module fcpe_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_type,
  output logic                     out_valid,
  input  logic                     out_ready,
  output fcpe_pkg::res_t           out_data,
  output fcpe_pkg::cmd_t           cmd,
  input  fcpe_pkg::sts_t           sts,
  input  logic [fcpe_pkg::TagW-1:0] hit_tag,
  input  logic [fcpe_pkg::TagW-1:0] cur_tag
);
  import fcpe_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_EVOUT = 4'd4;
  localparam logic [3:0] S_SHIFT = 4'd5;
  localparam logic [3:0] S_LOOK  = 4'd6;
  localparam logic [3:0] S_INVAL = 4'd7;
  localparam logic [3:0] S_WAIT  = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] rtype;
  logic [2:0] mode, mode_next;
  logic       ov, ov_next;
  res_t       res, res_next;
  logic       emitting;

  assign in_ready  = (state == S_IDLE) && !ov;
  assign out_valid = ov;
  assign out_data  = res;
  assign emitting  = ov && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
      mode  <= SCAN_OTHER;
    end else begin
      state <= state_next;
      ov    <= ov_next;
      mode  <= mode_next;
    end
    res <= res_next;
    if (in_valid && in_ready) rtype <= in_type;
  end

  always_comb begin
    state_next = state;
    mode_next  = mode;
    ov_next    = ov && !out_ready;
    res_next   = res;
    cmd        = '0;
    cmd.mode   = mode;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_req = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd.scan_start = 1'b1;
        case (rtype)
          REQ_INSERT: begin state_next = S_CHECK; mode_next = SCAN_OTHER; end
          REQ_EXACT:  begin state_next = S_LOOK;  mode_next = SCAN_EXACT; end
          REQ_NEAR:   begin state_next = S_LOOK;  mode_next = SCAN_NEAR; end
          default:    begin state_next = S_INVAL; mode_next = SCAN_INVAL; end
        endcase
      end
      // decide whether another eviction is due
      S_CHECK: begin
        cmd.scan_start = 1'b1;
        if (sts.need_evict) begin
          mode_next = SCAN_OTHER;
          state_next = S_SCAN;
        end else if (!ov) begin
          cmd.append = 1'b1;
          ov_next = 1'b1;
          res_next = '{result_kind: KIND_DONE, out_handle: '0, last: 1'b1};
          state_next = S_WAIT;
        end
      end
      // first-match scans stop early; the latest-time scan runs to the end
      S_SCAN: begin
        if (sts.found && mode != SCAN_LATE) begin
          state_next = S_EVOUT;
        end else if (sts.scan_end) begin
          cmd.scan_start = (mode != SCAN_LATE);
          mode_next = (mode == SCAN_OTHER) ? SCAN_PAST : SCAN_LATE;
          if (mode == SCAN_LATE) state_next = S_EVOUT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EVOUT: begin
        if (!ov) begin
          ov_next = 1'b1;
          res_next = '{result_kind: KIND_EVICT, out_handle: hit_tag, last: 1'b0};
          cmd.shift_start = 1'b1;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.scan_end) state_next = S_CHECK;
        else cmd.remove = 1'b1;
      end
      S_LOOK: begin
        if (sts.scan_end || (mode == SCAN_EXACT && sts.found)) begin
          if (!ov) begin
            ov_next = 1'b1;
            res_next = sts.found ?
              '{result_kind: KIND_HIT, out_handle: hit_tag, last: 1'b1} :
              '{result_kind: KIND_MISS, out_handle: '0, last: 1'b1};
            state_next = S_WAIT;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_INVAL: begin
        if (sts.scan_end) begin
          if (!ov) begin
            cmd.inval_fin = 1'b1;
            ov_next = 1'b1;
            res_next = '{result_kind: KIND_DONE, out_handle: '0, last: 1'b1};
            state_next = S_WAIT;
          end
        end else if (sts.inval_match) begin
          if (!ov) begin
            ov_next = 1'b1;
            res_next = '{result_kind: KIND_EVICT, out_handle: cur_tag, last: 1'b0};
            cmd.scan_step = 1'b1;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_WAIT: begin
        if (!emitting) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/frame_cache_priority_evict.sv -----
// ----------------------------------------------------------------------------
// Frame cache with priority eviction
// Insertion-ordered table of frame entries with insert, exact and nearest
// lookup and clip invalidation.
//
//   channel | dir | payload
//   req     | in  | req_type clip_id timestamp_ms frame_bytes frame_handle
//           |     | max_distance_ms
//   res     | out | result_kind out_handle last
//   cfg     | in  | cfg_we cfg_index cfg_data (no read-back)
//
// One request at a time, taken only when idle. A lookup scans the table once
// and then answers (an exact hit stops early). An insert runs per eviction up
// to three scans (another clip, a past frame, the latest time) and one shift
// pass, then appends. Invalidate makes one compacting pass, in which each
// removed entry waits for the output register.
// A result waits in the output register; the controller stalls on it.
// Synchronous active-high reset empties the table and loads register defaults.
// ----------------------------------------------------------------------------
module frame_cache_priority_evict #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  fcpe_if.sink                         req,
  fcpe_if.source                       res,
  input  logic                         cfg_we,
  input  logic [fcpe_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [fcpe_pkg::LimitW-1:0]  cfg_data
);
  import fcpe_pkg::*;

  cmd_t           cmd;
  sts_t           sts;
  logic [TagW-1:0] hit_tag;
  logic [TagW-1:0] cur_tag;
  req_t           rq;

  assign rq = req.data;

  fcpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_type   (rq.req_type),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res.data),
    .cmd       (cmd),
    .sts       (sts),
    .hit_tag   (hit_tag),
    .cur_tag   (cur_tag)
  );

  fcpe_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req_in   (rq),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_data),
    .hit_tag  (hit_tag),
    .cur_tag  (cur_tag)
  );

endmodule

// ----- rtl/fcpe_checker.sv -----
// ----------------------------------------------------------------------------
// Frame cache port checker
// Watches the request and result channels of the frame cache.
// ----------------------------------------------------------------------------
module fcpe_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          res_valid,
  input logic          res_ready,
  input fcpe_pkg::res_t res_data
);
  import fcpe_pkg::*;

  // a result that waits holds still
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // no new request taken in the cycle after one was taken
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken back to back");

  // hit and miss results always close the request
  a_hit_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.result_kind == KIND_HIT ||
                  res_data.result_kind == KIND_MISS) |-> res_data.last)
    else $error("lookup result not last");

  // done carries handle zero and last
  a_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.result_kind == KIND_DONE |->
      res_data.last && res_data.out_handle == '0)
    else $error("malformed done result");
endmodule

bind frame_cache_priority_evict fcpe_checker u_fcpe_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);

// ----- dv/frame_cache_priority_evict_tb.sv -----
// ----------------------------------------------------------------------------
// Frame cache testbench
// Drives insert, lookup and invalidate requests through the valid/ready
// channels under several idling phases and register settings, and checks
// every result against an in-bench model of the cache table.
// ----------------------------------------------------------------------------
import fcpe_pkg::*;

// Cache model and queue of predicted results
class frame_cache_board;
  logic [LimitW-1:0] byte_limit;
  logic [WinW-1:0]   exact_win;
  logic [MargW-1:0]  past_marg;
  int unsigned       count;
  logic [ClipW-1:0]  clip_tab[16];
  logic [TimeW-1:0]  time_tab[16];
  logic [SizeW-1:0]  size_tab[16];
  logic [TagW-1:0]   tag_tab[16];
  logic [39:0]       total;
  res_t              pending[$];
  int                errors;

  function new();
    byte_limit = BYTE_LIMIT_RST;
    exact_win  = EXACT_WIN_RST;
    past_marg  = PAST_MARG_RST;
    count = 0;
    total = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [LimitW-1:0] val);
    if (idx == CFG_BYTE_LIMIT) byte_limit = val;
    else if (idx == CFG_EXACT_WIN) exact_win = val[WinW-1:0];
    else if (idx == CFG_PAST_MARG) past_marg = val[MargW-1:0];
  endfunction

  function void push(logic [1:0] kind, logic [TagW-1:0] h, logic lst);
    res_t r;
    r.result_kind = kind;
    r.out_handle = h;
    r.last = lst;
    pending = {pending, r};
  endfunction

  function logic [32:0] gap_ms(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    return (a > b) ? {1'b0, a} - {1'b0, b} : {1'b0, b} - {1'b0, a};
  endfunction

  function void drop(int unsigned idx);
    total -= size_tab[idx];
    for (int unsigned i = idx; i + 1 < count; i++) begin
      clip_tab[i] = clip_tab[i+1];
      time_tab[i] = time_tab[i+1];
      size_tab[i] = size_tab[i+1];
      tag_tab[i]  = tag_tab[i+1];
    end
    count--;
  endfunction

  function int unsigned victim(logic [ClipW-1:0] clip, logic [TimeW-1:0] ts);
    int unsigned best;
    best = 0;
    for (int unsigned i = 0; i < count; i++)
      if (clip_tab[i] != clip) return i;
    for (int unsigned i = 0; i < count; i++)
      if ({1'b0, time_tab[i]} + past_marg < {1'b0, ts}) return i;
    for (int unsigned i = 1; i < count; i++)
      if (time_tab[i] > time_tab[best]) best = i;
    return best;
  endfunction

  // Accepted request: update the table and queue its results
  function void note_request(req_t q);
    logic        hit;
    logic [32:0] best_d, d;
    int unsigned bi, j;
    hit = 0;
    bi = 0;
    j = 0;
    best_d = {1'b0, q.max_distance_ms};
    case (q.req_type)
      REQ_INSERT: begin
        while (count > 0 && (count >= 16 || total + q.frame_bytes > byte_limit)) begin
          bi = victim(q.clip_id, q.timestamp_ms);
          push(KIND_EVICT, tag_tab[bi], 1'b0);
          drop(bi);
        end
        clip_tab[count] = q.clip_id;
        time_tab[count] = q.timestamp_ms;
        size_tab[count] = q.frame_bytes;
        tag_tab[count]  = q.frame_handle;
        count++;
        total += q.frame_bytes;
        push(KIND_DONE, '0, 1'b1);
      end
      REQ_EXACT: begin
        for (int unsigned i = 0; i < count; i++)
          if (!hit && clip_tab[i] == q.clip_id &&
              gap_ms(time_tab[i], q.timestamp_ms) < exact_win) begin
            hit = 1;
            bi = i;
          end
        if (hit) push(KIND_HIT, tag_tab[bi], 1'b1);
        else push(KIND_MISS, '0, 1'b1);
      end
      REQ_NEAR: begin
        for (int unsigned i = 0; i < count; i++)
          if (clip_tab[i] == q.clip_id) begin
            d = gap_ms(time_tab[i], q.timestamp_ms);
            if (d <= best_d && (!hit || d < best_d)) begin
              hit = 1;
              best_d = d;
              bi = i;
            end
          end
        if (hit) push(KIND_HIT, tag_tab[bi], 1'b1);
        else push(KIND_MISS, '0, 1'b1);
      end
      default: begin
        for (int unsigned i = 0; i < count; i++) begin
          if (clip_tab[i] == q.clip_id) begin
            push(KIND_EVICT, tag_tab[i], 1'b0);
            total -= size_tab[i];
          end else begin
            clip_tab[j] = clip_tab[i];
            time_tab[j] = time_tab[i];
            size_tab[j] = size_tab[i];
            tag_tab[j]  = tag_tab[i];
            j++;
          end
        end
        count = j;
        push(KIND_DONE, '0, 1'b1);
      end
    endcase
  endfunction

  // Accepted result: compare with the oldest prediction
  function void check_result(res_t r);
    res_t e;
    if (pending.size() == 0) begin
      $error("unexpected result kind %0d handle %0h", r.result_kind, r.out_handle);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (r.result_kind !== e.result_kind) begin
      $error("result_kind: expected %0d, got %0d", e.result_kind, r.result_kind);
      errors++;
    end
    if (r.out_handle !== e.out_handle) begin
      $error("out_handle: expected %0h, got %0h", e.out_handle, r.out_handle);
      errors++;
    end
    if (r.last !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, r.last);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [LimitW-1:0]   cfg_data;
  int unsigned         send_idle;
  int unsigned         recv_stall;
  bit                  drain_done;
  frame_cache_board    board;

  fcpe_if #(.payload_t(req_t)) req_ch ();
  fcpe_if #(.payload_t(res_t)) res_ch ();

  frame_cache_priority_evict uut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .res(res_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) board.note_request(req_ch.data);
      if (res_ch.valid && res_ch.ready) board.check_result(res_ch.data);
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Valid stays high into the next request unless the sender idles
  task automatic send(req_t q);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.data  <= q;
    req_ch.valid <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_req(logic [1:0] kind, logic [ClipW-1:0] clip, logic [TimeW-1:0] ts,
                          logic [SizeW-1:0] nbytes, logic [TagW-1:0] h,
                          logic [TimeW-1:0] maxd);
    req_t q;
    q.req_type = kind;
    q.clip_id = clip;
    q.timestamp_ms = ts;
    q.frame_bytes = nbytes;
    q.frame_handle = h;
    q.max_distance_ms = maxd;
    send(q);
  endtask

  // Wait for every predicted result, then let the block settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LimitW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly a few clips with clustered times, occasionally full-range fields
  task automatic random_req();
    logic [1:0]       kind;
    logic [ClipW-1:0] clip;
    logic [TimeW-1:0] ts;
    logic [SizeW-1:0] nbytes;
    logic [TimeW-1:0] maxd;
    kind = ($urandom_range(9) < 5) ? REQ_INSERT : 2'($urandom_range(3));
    clip = ($urandom_range(9) == 0) ? ClipW'($urandom) : ClipW'($urandom_range(3));
    ts = $urandom_range(9) == 0 ? $urandom : $urandom_range(1200);
    nbytes = $urandom_range(3) == 0 ? $urandom : $urandom_range(40000000);
    maxd = $urandom_range(5) == 0 ? $urandom : $urandom_range(300);
    send_req(kind, clip, ts, nbytes, TagW'($urandom), maxd);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_BYTE_LIMIT;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    drain_done = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, extremes, all requests, eviction priorities
    send_req(REQ_EXACT, 16'd1, 32'd100, 32'd0, 16'd0, 32'd0);
    send_req(REQ_NEAR, 16'd1, 32'd100, 32'd0, 16'd0, 32'hFFFF_FFFF);
    send_req(REQ_INVAL, 16'd1, 32'd0, 32'd0, 16'd0, 32'd0);
    send_req(REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'd1000, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(REQ_INSERT, 16'd0, 32'd0, 32'd2000, 16'h0001, 32'd0);
    send_req(REQ_INSERT, 16'd0, 32'd500, 32'd3000, 16'h0002, 32'd0);
    send_req(REQ_EXACT, 16'd0, 32'd544, 32'd0, 16'd0, 32'd0);
    send_req(REQ_EXACT, 16'd0, 32'd545, 32'd0, 16'd0, 32'd0);
    send_req(REQ_NEAR, 16'd0, 32'd250, 32'd0, 16'd0, 32'd250);
    send_req(REQ_NEAR, 16'hFFFF, 32'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
    // oversized frame empties the table and is still stored
    send_req(REQ_INSERT, 16'd0, 32'd400, 32'hFFFF_FFFF, 16'h0003, 32'd0);
    send_req(REQ_INSERT, 16'd0, 32'd900, 32'h0100_0000, 16'h0004, 32'd0);
    send_req(REQ_INVAL, 16'd0, 32'd0, 32'd0, 16'd0, 32'd0);
    // fill one clip to force latest-frame eviction
    for (int i = 0; i < 17; i++)
      send_req(REQ_INSERT, 16'd5, 32'(1000 - i * 10), 32'd10, 16'(16'h100 + i), 32'd0);
    send_req(REQ_INVAL, 16'd5, 32'd0, 32'd0, 16'd0, 32'd0);
    drain();

    // Random phases under different settings and idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 88; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 88; end
        3: begin send_idle = 23; recv_stall = 23; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      case (ph)
        0: begin
          write_reg(CFG_BYTE_LIMIT, 40'd100000000);
          write_reg(CFG_EXACT_WIN, 40'd0);
          write_reg(CFG_PAST_MARG, 40'd0);
        end
        1: begin
          write_reg(CFG_BYTE_LIMIT, 40'hFF_FFFF_FFFF);
          write_reg(CFG_EXACT_WIN, 40'd1000);
          write_reg(CFG_PAST_MARG, 40'd10000);
        end
        2: begin
          write_reg(CFG_BYTE_LIMIT, 40'd0);
          write_reg(CFG_EXACT_WIN, 40'h3FF);
          write_reg(CFG_PAST_MARG, 40'h3FFF);
        end
        3: begin
          write_reg(CFG_BYTE_LIMIT, 40'd60000000);
          write_reg(CFG_EXACT_WIN, 40'd45);
          write_reg(CFG_PAST_MARG, 40'd150);
        end
        default: write_reg(CFG_BYTE_LIMIT, {$urandom, 8'($urandom)});
      endcase
      for (int n = 0; n < 40; n++) random_req();
      drain();
    end
    drain_done = 1;
  end

  // Final verdict
  initial begin
    wait (drain_done);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("frame_cache_priority_evict verification clean");
    else
      $display("frame_cache_priority_evict verification failed");
    $finish;
  end

  // Timeout
  initial begin
    #40000000;
    $display("frame_cache_priority_evict verification failed");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/fcpe_pkg.sv
rtl/fcpe_if.sv
rtl/fcpe_dp.sv
rtl/fcpe_ctrl.sv
rtl/frame_cache_priority_evict.sv
rtl/fcpe_checker.sv
dv/frame_cache_priority_evict_tb.sv
